// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 16;
    localparam int OUT_CNT_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_HIGH      = 3'd0,
        CFG_BUTTON_KIND      = 3'd1,
        CFG_COUNT_ON_RELEASE = 3'd2,
        CFG_ACCUMULATE       = 3'd3,
        CFG_INITIAL_DELAY    = 3'd4,
        CFG_REPEAT_DELAY     = 3'd5,
        CFG_ENABLED          = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_SINGLE    = 2'd0,
        KIND_LONG      = 2'd1,
        KIND_TYPEMATIC = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SINGLE_HELD = 3'd1,
        PH_LONG_WAIT   = 3'd2,
        PH_LONG_HELD   = 3'd3,
        PH_QUIET_HELD  = 3'd4,
        PH_TYPE_FIRST  = 3'd5,
        PH_TYPE_REPEAT = 3'd6
    } phase_t;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd500;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd100;
    localparam logic [DELAY_W-1:0] TIMER_MAX         = 16'hFFFF;

    typedef struct packed {
        logic               active_high;
        logic [1:0]         button_kind;
        logic               count_on_release;
        logic               accumulate;
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] repeat_delay;
        logic               enabled;
    } cfg_t;

    // Debouncer view for the current transaction
    typedef struct packed {
        logic level;
        logic settled;
    } db_t;

    typedef struct packed {
        logic pin_level;
        logic take;
    } sample_t;

    typedef struct packed {
        logic                 depressed;
        logic [OUT_CNT_W-1:0] push_count;
        logic                 long_push;
    } result_t;

endpackage

// ===== hdl/bpc_config.sv =====
// ----------------------------------------------------------------------------
// bpc_config
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module bpc_config (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output bpc_pkg::cfg_t                  cfg
);
    import bpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high      <= 1'b0;
            cfg_reg.button_kind      <= KIND_SINGLE;
            cfg_reg.count_on_release <= 1'b0;
            cfg_reg.accumulate       <= 1'b0;
            cfg_reg.initial_delay    <= INITIAL_DELAY_RST;
            cfg_reg.repeat_delay     <= REPEAT_DELAY_RST;
            cfg_reg.enabled          <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_HIGH:      cfg_reg.active_high      <= cfg_data[0];
                CFG_BUTTON_KIND:      cfg_reg.button_kind      <= cfg_data[1:0];
                CFG_COUNT_ON_RELEASE: cfg_reg.count_on_release <= cfg_data[0];
                CFG_ACCUMULATE:       cfg_reg.accumulate       <= cfg_data[0];
                CFG_INITIAL_DELAY:    cfg_reg.initial_delay    <= cfg_data[DELAY_W-1:0];
                CFG_REPEAT_DELAY:     cfg_reg.repeat_delay     <= cfg_data[DELAY_W-1:0];
                CFG_ENABLED:          cfg_reg.enabled          <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/bpc_debounce.sv =====
// ----------------------------------------------------------------------------
// bpc_debounce
// Run-length debouncer: a level is taken once it holds for STABLE_TICKS.
// ----------------------------------------------------------------------------
module bpc_debounce #(
    parameter int STABLE_TICKS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         pin_level,
    output bpc_pkg::db_t db
);
    import bpc_pkg::*;

    localparam int SC_W = $clog2(STABLE_TICKS + 1);
    localparam logic [SC_W-1:0] SC_FULL = SC_W'(STABLE_TICKS);

    logic            level_reg,  level_next;
    logic            prev_reg,   prev_next;
    logic [SC_W-1:0] count_reg,  count_next;
    logic            settled;

    always_comb
    begin
        prev_next  = prev_reg;
        count_next = count_reg;
        if (pin_level == prev_reg)
        begin
            if (count_reg < SC_FULL)
                count_next = count_reg + 1'b1;
        end
        else
        begin
            prev_next  = pin_level;
            count_next = SC_W'(1);
        end
        settled    = (count_next >= SC_FULL);
        level_next = settled ? prev_next : level_reg;
    end

    // Released level after reset is high, matching the default pull-up polarity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b1;
            prev_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

    assign db.level   = level_next;
    assign db.settled = settled;

endmodule

// ===== hdl/bpc_phase.sv =====
// ----------------------------------------------------------------------------
// bpc_phase
// Press phase machine: hold timer, push counter and long-push flag.
// ----------------------------------------------------------------------------
module bpc_phase #(
    parameter int COUNT_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              take,
    input  bpc_pkg::cfg_t     cfg,
    input  bpc_pkg::db_t      db,
    output bpc_pkg::result_t  result
);
    import bpc_pkg::*;

    localparam int CNT_W = (COUNT_BITS >= OUT_CNT_W) ? OUT_CNT_W : COUNT_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    phase_t             phase_reg,   phase_next;
    logic [DELAY_W-1:0] hold_reg,    hold_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic               long_reg,    long_next;
    logic               pressed_reg, pressed_next;

    logic [DELAY_W-1:0] hold_inc;
    logic [DELAY_W-1:0] delay;
    logic               released;
    logic               wait_done;
    logic               push_ev;
    logic               long_ev;

    always_comb
    begin
        released  = (db.level == ~cfg.active_high);
        hold_inc  = (hold_reg != TIMER_MAX) ? hold_reg + 1'b1 : hold_reg;
        delay     = (phase_reg == PH_TYPE_REPEAT) ? cfg.repeat_delay : cfg.initial_delay;
        wait_done = (hold_inc >= delay);

        phase_next   = phase_reg;
        hold_next    = hold_reg;
        pressed_next = pressed_reg;
        push_ev      = 1'b0;
        long_ev      = 1'b0;

        case (phase_reg)
            PH_SINGLE_HELD, PH_LONG_HELD, PH_QUIET_HELD:
            begin
                if (released)
                begin
                    pressed_next = 1'b0;
                    if (cfg.count_on_release)
                    begin
                        push_ev = (phase_reg == PH_SINGLE_HELD);
                        long_ev = (phase_reg == PH_LONG_HELD);
                    end
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG_WAIT:
            begin
                if (released)
                begin
                    pressed_next = 1'b0;
                    push_ev      = 1'b1;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    hold_next = hold_inc;
                    if (wait_done)
                    begin
                        hold_next = '0;
                        // Still bouncing: wait out the release without a push
                        if (!db.settled)
                            phase_next = PH_QUIET_HELD;
                        else
                        begin
                            long_ev    = ~cfg.count_on_release;
                            phase_next = PH_LONG_HELD;
                        end
                    end
                end
            end
            PH_TYPE_FIRST, PH_TYPE_REPEAT:
            begin
                if (released)
                begin
                    pressed_next = 1'b0;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    hold_next = hold_inc;
                    if (wait_done)
                    begin
                        hold_next  = '0;
                        push_ev    = db.settled;
                        phase_next = PH_TYPE_REPEAT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (cfg.enabled && (db.level == cfg.active_high))
                begin
                    pressed_next = 1'b1;
                    hold_next    = '0;
                    case (cfg.button_kind)
                        KIND_SINGLE:
                        begin
                            push_ev    = ~cfg.count_on_release;
                            phase_next = PH_SINGLE_HELD;
                        end
                        KIND_LONG:
                        begin
                            phase_next = PH_LONG_WAIT;
                        end
                        default:
                        begin
                            push_ev    = 1'b1;
                            phase_next = PH_TYPE_FIRST;
                        end
                    endcase
                end
            end
        endcase

        cnt_next  = cnt_reg;
        long_next = long_reg;
        if (long_ev)
        begin
            cnt_next  = '0;
            long_next = 1'b1;
        end
        else if (push_ev)
        begin
            if (!cfg.accumulate)
                cnt_next = CNT_W'(1);
            else if (cnt_reg != CNT_MAX)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hold_reg    <= '0;
            cnt_reg     <= '0;
            long_reg    <= 1'b0;
            pressed_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            pressed_reg <= pressed_next;
            // Take clears after this transaction's result is formed
            cnt_reg     <= take ? '0 : cnt_next;
            long_reg    <= take ? 1'b0 : long_next;
        end
    end

    assign result.depressed  = pressed_next;
    assign result.push_count = OUT_CNT_W'(cnt_next);
    assign result.long_push  = long_next;

endmodule

// ===== hdl/button_press_classifier_unit.sv =====
// A result is registered and valid in the cycle after its sample transaction.
// Throughput: one sample per cycle; all state updates in the cycle of acceptance.
// A single output register decouples the sides: input stalls only while a held
// result is not taken.
// Reset (rst_n, async low): configuration to defaults, debouncer to released
// level, phase machine idle, counters and flags cleared, no result pending.
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Debounced push button with single, long-press and auto-repeat counting.
// ----------------------------------------------------------------------------
module button_press_classifier_unit #(
    parameter int STABLE_TICKS = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  bpc_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output bpc_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpc_pkg::*;

    cfg_t    cfg;
    db_t     db;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    assign sample_ready = ~result_valid_reg | result_ready;
    assign advance      = sample_valid & sample_ready;

    bpc_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_debounce #(
        .STABLE_TICKS (STABLE_TICKS)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pin_level (sample.pin_level),
        .db        (db)
    );

    bpc_phase #(
        .COUNT_BITS (COUNT_BITS)
    ) u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .take    (sample.take),
        .cfg     (cfg),
        .db      (db),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (sample_ready)
            result_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the classifier handshake and output register.
// ----------------------------------------------------------------------------
module bpc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input bpc_pkg::result_t result
);
    import bpc_pkg::*;

    // Hold a stalled result transaction unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // Every accepted sample yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> result_valid)
        else $error("accepted sample produced no result");

    // Empty output register must not block input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled with empty output register");

    // A held result that is not taken must block input
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !sample_ready)
        else $error("input accepted while result stalled");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== dv/button_press_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_checker
// Watches the sample, result and register ports of the button press
// classifier, predicts the pressed state, push count and long flag of every
// accepted sample transaction, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module button_press_checker #(
    parameter int STABLE_TICKS = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic                           sample_ready,
    input  bpc_pkg::sample_t               sample,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  bpc_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import bpc_pkg::*;

    localparam int COUNT_MAX = (COUNT_BITS >= 8) ? 255 : (1 << COUNT_BITS) - 1;

    typedef enum {HOLD_RUNNING, HOLD_RELEASED, HOLD_ELAPSED, HOLD_UNSETTLED} hold_t;

    // register copies
    logic               c_active_high;
    logic [1:0]         c_kind;
    logic               c_on_release;
    logic               c_accumulate;
    logic [DELAY_W-1:0] c_first;
    logic [DELAY_W-1:0] c_repeat;
    logic               c_enabled;

    // predicted block state
    logic               db_level;
    logic               last_pin;
    int                 run_len;
    phase_t             press_phase;
    logic [DELAY_W-1:0] hold_ticks;
    int                 pushes;
    logic               long_seen;
    logic               held;

    result_t            pending_results[$];

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want_v);
        mismatches++;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (cfg_idx_t'(idx))
            CFG_ACTIVE_HIGH:      c_active_high = data[0];
            CFG_BUTTON_KIND:      c_kind        = data[1:0];
            CFG_COUNT_ON_RELEASE: c_on_release  = data[0];
            CFG_ACCUMULATE:       c_accumulate  = data[0];
            CFG_INITIAL_DELAY:    c_first       = data[DELAY_W-1:0];
            CFG_REPEAT_DELAY:     c_repeat      = data[DELAY_W-1:0];
            CFG_ENABLED:          c_enabled     = data[0];
            default:              ;
        endcase
    endtask

    task automatic bump_count();
        if (c_accumulate)
        begin
            if (pushes < COUNT_MAX)
                pushes++;
        end
        else
            pushes = 1;
    endtask

    task automatic mark_long();
        pushes    = 0;
        long_seen = 1'b1;
    endtask

    // Advance the hold timer; a settled release ends the wait first.
    function automatic hold_t timed_hold(input logic [DELAY_W-1:0] limit, input logic rel);
        if (db_level == rel)
            return HOLD_RELEASED;
        if (hold_ticks < TIMER_MAX)
            hold_ticks++;
        if (hold_ticks < limit)
            return HOLD_RUNNING;
        hold_ticks = '0;
        if (run_len < STABLE_TICKS)
            return HOLD_UNSETTLED;
        return HOLD_ELAPSED;
    endfunction

    task automatic classify_sample(input sample_t s, output result_t r);
        logic  prs;
        logic  rel;
        hold_t w;
        prs = c_active_high;
        rel = ~c_active_high;

        if (s.pin_level == last_pin)
        begin
            if (run_len < STABLE_TICKS)
                run_len++;
        end
        else
        begin
            last_pin = s.pin_level;
            run_len  = 1;
        end
        if (run_len >= STABLE_TICKS)
            db_level = last_pin;

        case (press_phase)
            PH_SINGLE_HELD, PH_LONG_HELD, PH_QUIET_HELD:
            begin
                if (db_level == rel)
                begin
                    held = 1'b0;
                    if (c_on_release)
                    begin
                        if (press_phase == PH_SINGLE_HELD)
                            bump_count();
                        else if (press_phase == PH_LONG_HELD)
                            mark_long();
                    end
                    press_phase = PH_IDLE;
                end
            end
            PH_LONG_WAIT:
            begin
                w = timed_hold(c_first, rel);
                if (w == HOLD_RELEASED)
                begin
                    held = 1'b0;
                    bump_count();
                    press_phase = PH_IDLE;
                end
                else if (w == HOLD_UNSETTLED)
                    press_phase = PH_QUIET_HELD;
                else if (w == HOLD_ELAPSED)
                begin
                    if (!c_on_release)
                        mark_long();
                    press_phase = PH_LONG_HELD;
                end
            end
            PH_TYPE_FIRST, PH_TYPE_REPEAT:
            begin
                w = timed_hold((press_phase == PH_TYPE_FIRST) ? c_first : c_repeat, rel);
                if (w == HOLD_RELEASED)
                begin
                    held = 1'b0;
                    press_phase = PH_IDLE;
                end
                else if (w != HOLD_RUNNING)
                begin
                    // bouncing at the end of a delay skips this repeat only
                    if (w == HOLD_ELAPSED)
                        bump_count();
                    press_phase = PH_TYPE_REPEAT;
                end
            end
            default:
            begin
                press_phase = PH_IDLE;
                if (c_enabled && db_level == prs)
                begin
                    held       = 1'b1;
                    hold_ticks = '0;
                    if (c_kind == KIND_SINGLE)
                    begin
                        if (!c_on_release)
                            bump_count();
                        press_phase = PH_SINGLE_HELD;
                    end
                    else if (c_kind == KIND_LONG)
                        press_phase = PH_LONG_WAIT;
                    else
                    begin
                        bump_count();
                        press_phase = PH_TYPE_FIRST;
                    end
                end
            end
        endcase

        r.depressed  = held;
        r.push_count = pushes[OUT_CNT_W-1:0];
        r.long_push  = long_seen;

        // take clears after the result is formed
        if (s.take)
        begin
            pushes    = 0;
            long_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            c_active_high = 1'b0;
            c_kind        = KIND_SINGLE;
            c_on_release  = 1'b0;
            c_accumulate  = 1'b0;
            c_first       = INITIAL_DELAY_RST;
            c_repeat      = REPEAT_DELAY_RST;
            c_enabled     = 1'b1;
            // released level under the reset polarity
            db_level      = 1'b1;
            last_pin      = 1'b1;
            run_len       = 0;
            press_phase   = PH_IDLE;
            hold_ticks    = '0;
            pushes        = 0;
            long_seen     = 1'b0;
            held          = 1'b0;
            pending_results.delete();
            mismatches    = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
            begin
                classify_sample(sample, want);
                pending_results.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, push_count",
                                    int'(result.push_count), 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.depressed !== want.depressed)
                        report_mismatch("depressed", int'(result.depressed),
                                        int'(want.depressed));
                    if (result.push_count !== want.push_count)
                        report_mismatch("push_count", int'(result.push_count),
                                        int'(want.push_count));
                    if (result.long_push !== want.long_push)
                        report_mismatch("long_push", int'(result.long_push),
                                        int'(want.long_push));
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/tb_button_press_classifier_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier_unit
// Drives pin samples through the button press classifier in press episodes
// with bounce, glitches and noise, over a sequence of register settings, with
// random gaps on the sample side and random stalls on the result side. The
// checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_unit;
    import bpc_pkg::*;

    localparam int STABLE_TICKS = 16;
    localparam int LIMIT        = 1000000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample_in    = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_out;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   stall_left  = 0;
    int   take_odds   = 4;
    int   phase_items = 0;
    logic calm        = 1'b1;
    logic pressed_lvl = 1'b0;

    button_press_classifier_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    button_press_checker #(.STABLE_TICKS(STABLE_TICKS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic take_now();
        return (take_odds > 0) && ($urandom_range(1, take_odds) == 1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = gap_len();
        end
    end

    task automatic send_tick(input logic pin, input logic tk);
        int      g;
        sample_t s;
        s.pin_level = pin;
        s.take      = tk;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= s;
        do @(posedge clk); while (!sample_ready);
        phase_items++;
    endtask

    // hold the sender until every result has come back
    task automatic drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic bounce(input logic lvl);
        repeat ($urandom_range(1, 3)) send_tick(lvl, take_now());
        repeat ($urandom_range(1, 3)) send_tick(~lvl, take_now());
    endtask

    task automatic press_episode(input int max_hold);
        int   n;
        logic prs;
        logic rel;
        prs = pressed_lvl;
        rel = ~pressed_lvl;
        repeat ($urandom_range(0, 3)) bounce(prs);
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(1, STABLE_TICKS);
        else
            n = STABLE_TICKS + $urandom_range(0, max_hold);
        // occasional one-tick glitches keep the debouncer unsettled at delay ends
        repeat (n) send_tick(($urandom_range(0, 24) == 0) ? rel : prs, take_now());
        repeat ($urandom_range(0, 3)) bounce(rel);
        repeat ($urandom_range(STABLE_TICKS, STABLE_TICKS + 12)) send_tick(rel, take_now());
    endtask

    task automatic run_phase(input logic ah, input logic [1:0] kind, input logic cor,
                             input logic acc, input logic [DELAY_W-1:0] fd,
                             input logic [DELAY_W-1:0] rd, input logic en,
                             input int n, input int max_hold, input int odds);
        drain();
        write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'(ah));
        write_reg(CFG_BUTTON_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_COUNT_ON_RELEASE, CFG_DATA_W'(cor));
        write_reg(CFG_ACCUMULATE, CFG_DATA_W'(acc));
        write_reg(CFG_INITIAL_DELAY, fd);
        write_reg(CFG_REPEAT_DELAY, rd);
        write_reg(CFG_ENABLED, CFG_DATA_W'(en));
        cfg_we      <= 1'b0;
        pressed_lvl = ah;
        take_odds   = odds;
        phase_items = 0;
        calm        = ($urandom_range(0, 3) == 0);
        while (phase_items < n)
        begin
            if ($urandom_range(0, 9) < 7)
                press_episode(max_hold);
            else
                repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)), take_now());
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single mode, pressed level low
        calm = 1'b1;
        repeat (2) send_tick(1'b1, 1'b0);
        repeat (17) send_tick(1'b0, 1'b0);
        repeat (2) send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b1, 1'b1);

        run_phase(1'b0, KIND_SINGLE, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1, 20, 60, 4);
        run_phase(1'b1, KIND_SINGLE, 1'b1, 1'b1, 16'd5, 16'd3, 1'b1, 20, 60, 6);
        run_phase(1'b0, KIND_LONG, 1'b0, 1'b1, 16'd20, 16'd7, 1'b1, 20, 70, 5);
        run_phase(1'b1, KIND_LONG, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1, 15, 50, 4);
        run_phase(1'b0, KIND_LONG, 1'b1, 1'b1, 16'd30, 16'd2, 1'b1, 20, 80, 8);
        run_phase(1'b1, KIND_TYPEMATIC, 1'b0, 1'b1, 16'd10, 16'd0, 1'b1, 20, 70, 6);
        // unnamed kind behaves as auto-repeat
        run_phase(1'b0, 2'b11, 1'b1, 1'b0, 16'd0, 16'd1, 1'b1, 15, 50, 4);
        run_phase(1'b1, KIND_TYPEMATIC, 1'b0, 1'b1, 16'd12, 16'd5, 1'b0, 15, 50, 4);
        run_phase(1'b0, KIND_LONG, 1'b0, 1'b1, TIMER_MAX, TIMER_MAX, 1'b1, 15, 60, 4);
        // repeat every tick with no take, to drive the count into saturation
        run_phase(1'b0, KIND_TYPEMATIC, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1, 330, 290, 0);
        repeat (4)
            run_phase(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      DELAY_W'($urandom_range(0, 40)), DELAY_W'($urandom_range(0, 15)),
                      ($urandom_range(0, 7) != 0), 15, 60, $urandom_range(0, 8));

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bpc_pkg.sv
hdl/bpc_config.sv
hdl/bpc_debounce.sv
hdl/bpc_phase.sv
hdl/button_press_classifier_unit.sv
hdl/bpc_checker.sv
dv/button_press_checker.sv
dv/tb_button_press_classifier_unit.sv
